FILE: rtl/cms_pkg.sv
// Shared types, constants and state encodings for the count-min sketch.
package cms_pkg;

   localparam logic [1:0] KIND_ADD      = 2'd0;
   localparam logic [1:0] KIND_ESTIMATE = 2'd1;
   localparam logic [1:0] KIND_CLEAR    = 2'd2;

   localparam logic [63:0] FMIX_C1    = 64'hff51_afd7_ed55_8ccd;
   localparam logic [63:0] FMIX_C2    = 64'hc4ce_b9fe_1a85_ec53;
   localparam int          FMIX_SHIFT = 33;

   localparam logic [31:0] THRESH_RESET = 32'd4096;
   localparam logic [31:0] EST_MAX      = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [1:0]  kind;
      logic [63:0] key;
   } req_type;

   typedef struct packed {
      logic [31:0] count_estimate;
      logic        flush_needed;
   } rsp_type;

   typedef enum logic [1:0] {
      H_IDLE,
      H_MUL,
      H_MOD,
      H_DONE
   } hash_state_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_START,
      S_HASH,
      S_READ,
      S_UPDATE,
      S_DONE
   } cms_state_type;

endpackage

FILE: rtl/count_min_sketch_top.sv
// Count-min sketch top level: control sequencer, flag, threshold and result register.
// Add or estimate: each row is hashed, read and updated in turn, and a power-of-two row
// width hashes faster than any other; the shared multiplier (two 64-bit multiplies, and
// a remainder for other widths) sets this.
// Clear: one counter per cycle, over all ROW_COUNT * ROW_WIDTH counters.
// Reset runs the same clearing pass with req_stall high.
module count_min_sketch_top #(
   parameter int ROW_WIDTH  = 1024,
   parameter int ROW_COUNT  = 4,
   parameter int COUNT_BITS = 32
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  cms_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output cms_pkg::rsp_type rsp_data,
   input  logic            csr_wr_en,
   input  logic [31:0]     csr_wr_data
);
   import cms_pkg::*;

   localparam int DEPTH     = ROW_COUNT * ROW_WIDTH;
   localparam int ADDR_BITS = $clog2(DEPTH);
   localparam int ROW_BITS  = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
   localparam int COL_BITS  = $clog2(ROW_WIDTH);
   localparam int CMP_BITS  = (COUNT_BITS > 32) ? COUNT_BITS : 32;
   localparam logic [ROW_BITS-1:0]  LAST_ROW  = ROW_BITS'(ROW_COUNT - 1);
   localparam logic [ADDR_BITS-1:0] LAST_ADDR = ADDR_BITS'(DEPTH - 1);

   cms_state_type          state_ff, state_in;
   logic [1:0]             kind_ff, kind_in;
   logic [63:0]            key_ff, key_in;
   logic [ROW_BITS-1:0]    row_ff, row_in;
   logic [COUNT_BITS-1:0]  min_ff, min_in;
   logic                   flag_ff, flag_in;
   logic [31:0]            thr_ff, thr_in;
   logic [ADDR_BITS-1:0]   clr_addr_ff, clr_addr_in;
   logic                   clr_resp_ff, clr_resp_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;

   logic                   accept;
   logic                   rsp_load;
   logic                   hash_start;
   logic                   hash_done;
   logic [COL_BITS-1:0]    hash_col;
   logic [ADDR_BITS-1:0]   slot_addr;
   logic                   mem_we;
   logic [ADDR_BITS-1:0]   mem_waddr;
   logic [COUNT_BITS-1:0]  mem_wdata;
   logic [COUNT_BITS-1:0]  mem_rdata;
   logic [COUNT_BITS-1:0]  cnt_inc;
   logic [CMP_BITS-1:0]    min_ext;
   logic [31:0]            est_value;

   cms_hash #(
      .ROW_WIDTH (ROW_WIDTH),
      .ROW_COUNT (ROW_COUNT)
   ) u_hash (
      .clock (clock),
      .reset (reset),
      .start (hash_start),
      .key   (key_ff),
      .row   (row_ff),
      .done  (hash_done),
      .col   (hash_col)
   );

   cms_store #(
      .DEPTH (DEPTH),
      .WIDTH (COUNT_BITS)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (slot_addr),
      .rd_data (mem_rdata)
   );

   assign slot_addr = ADDR_BITS'(row_ff) * ADDR_BITS'(ROW_WIDTH) + ADDR_BITS'(hash_col);
   assign cnt_inc   = (mem_rdata == '1) ? mem_rdata : mem_rdata + 1'b1;
   assign min_ext   = CMP_BITS'(min_ff);
   assign est_value = (min_ext > CMP_BITS'(EST_MAX)) ? EST_MAX : min_ext[31:0];
   assign accept    = req_valid && !req_stall;
   assign rsp_load  = (state_ff == S_DONE) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (clr_addr_ff == LAST_ADDR) begin
               state_in = clr_resp_ff ? S_DONE : S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               if (req_data.kind == KIND_ADD || req_data.kind == KIND_ESTIMATE) begin
                  state_in = S_START;
               end else if (req_data.kind == KIND_CLEAR) begin
                  state_in = S_CLEAR;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_START: begin
            state_in = S_HASH;
         end
         S_HASH: begin
            if (hash_done) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_UPDATE;
         end
         S_UPDATE: begin
            state_in = (row_ff == LAST_ROW) ? S_DONE : S_START;
         end
         S_DONE: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall  = (state_ff != S_IDLE);
      hash_start = (state_ff == S_START);
      mem_we     = 1'b0;
      mem_waddr  = slot_addr;
      mem_wdata  = cnt_inc;
      case (state_ff)
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_ff;
            mem_wdata = '0;
         end
         S_UPDATE: begin
            mem_we = (kind_ff == KIND_ADD);
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   always_comb begin
      kind_in      = kind_ff;
      key_in       = key_ff;
      row_in       = row_ff;
      min_in       = min_ff;
      flag_in      = flag_ff;
      thr_in       = csr_wr_en ? csr_wr_data : thr_ff;
      clr_addr_in  = clr_addr_ff;
      clr_resp_in  = clr_resp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         S_CLEAR: begin
            clr_addr_in = clr_addr_ff + 1'b1;
         end
         S_IDLE: begin
            if (accept) begin
               kind_in     = req_data.kind;
               key_in      = req_data.key;
               row_in      = '0;
               min_in      = '1;
               clr_addr_in = '0;
               clr_resp_in = 1'b1;
               if (req_data.kind == KIND_CLEAR) begin
                  flag_in = 1'b0;
               end
            end
         end
         S_UPDATE: begin
            row_in = (row_ff == LAST_ROW) ? '0 : row_ff + 1'b1;
            if (kind_ff == KIND_ADD) begin
               if (CMP_BITS'(cnt_inc) > CMP_BITS'(thr_ff)) begin
                  flag_in = 1'b1;
               end
            end else if (mem_rdata < min_ff) begin
               min_in = mem_rdata;
            end
         end
         S_DONE: begin
            if (rsp_load) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.count_estimate = (kind_ff == KIND_ESTIMATE) ? est_value : 32'd0;
               rsp_data_in.flush_needed   = flag_ff;
            end
         end
         default: begin
            row_in = row_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         kind_ff      <= KIND_ADD;
         row_ff       <= '0;
         flag_ff      <= 1'b0;
         thr_ff       <= THRESH_RESET;
         clr_addr_ff  <= '0;
         clr_resp_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         kind_ff      <= kind_in;
         row_ff       <= row_in;
         flag_ff      <= flag_in;
         thr_ff       <= thr_in;
         clr_addr_ff  <= clr_addr_in;
         clr_resp_ff  <= clr_resp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff      <= key_in;
      min_ff      <= min_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The sticky flag stays low for the whole clearing pass.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !flag_ff)
      else $error("flag set during clearing pass");

   // The hash unit reports completion only while the sequencer waits for it.
   assert property (@(posedge clock) disable iff (reset)
      hash_done |-> (state_ff == S_HASH))
      else $error("hash completion outside hash wait");

   // The row index never passes the last row.
   assert property (@(posedge clock) disable iff (reset)
      row_ff <= LAST_ROW)
      else $error("row index out of range");
endmodule

FILE: rtl/cms_mul.sv
// Shared 32 by 32 bit multiplier with a registered product.
module cms_mul (
   input  logic        clock,
   input  logic [31:0] mul_a,
   input  logic [31:0] mul_b,
   output logic [63:0] product
);
   import cms_pkg::*;

   logic [63:0] product_ff;
   logic [63:0] product_in;

   assign product_in = 64'(mul_a) * 64'(mul_b);

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;
endmodule

FILE: rtl/cms_store.sv
// Counter memory with one write port and one registered read port.
module cms_store #(
   parameter  int DEPTH      = 4096,
   parameter  int WIDTH      = 32,
   localparam int ADDR_BITS  = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);
   import cms_pkg::*;

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: rtl/cms_hash.sv
// Sequenced 64-bit finalizer hash and column reduction for one sketch row.
module cms_hash #(
   parameter  int ROW_WIDTH = 1024,
   parameter  int ROW_COUNT = 4,
   localparam int ROW_BITS  = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1,
   localparam int COL_BITS  = $clog2(ROW_WIDTH)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [63:0]         key,
   input  logic [ROW_BITS-1:0] row,
   output logic                done,
   output logic [COL_BITS-1:0] col
);
   import cms_pkg::*;

   localparam bit          IS_POW2  = ((ROW_WIDTH & (ROW_WIDTH - 1)) == 0);
   localparam logic [31:0] WIDTH_32 = 32'(ROW_WIDTH);
   localparam logic [31:0] RECIP    = 32'((64'd1 << 32) / 64'(ROW_WIDTH));

   hash_state_type      h_state_ff, h_state_in;
   logic [63:0]         v_ff, v_in;
   logic [63:0]         acc_ff, acc_in;
   logic [1:0]          ph_ff, ph_in;
   logic                sel_ff, sel_in;
   logic [1:0]          cnt_ff, cnt_in;
   logic [COL_BITS-1:0] rem_ff, rem_in;
   logic [COL_BITS-1:0] col_ff, col_in;

   logic [31:0] mul_a;
   logic [31:0] mul_b;
   logic [63:0] product;
   logic [63:0] const_sel;
   logic [63:0] x_val;
   logic [63:0] t_val;
   logic [31:0]         x_mod;
   logic [31:0]         x_diff;
   logic [COL_BITS-1:0] rem_step;

   cms_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .product (product)
   );

   assign const_sel = sel_ff ? FMIX_C2 : FMIX_C1;
   assign x_val     = key ^ 64'(row);
   assign t_val     = {acc_ff[63:32] + product[31:0], acc_ff[31:0]};
   assign x_mod     = {16'(rem_ff), v_ff[63:48]};
   assign x_diff    = x_mod - product[31:0];
   assign rem_step  = (x_diff >= WIDTH_32) ? COL_BITS'(x_diff - WIDTH_32)
                                           : COL_BITS'(x_diff);

   always_comb begin
      h_state_in = h_state_ff;
      case (h_state_ff)
         H_IDLE: begin
            if (start) begin
               h_state_in = H_MUL;
            end
         end
         H_MUL: begin
            if (ph_ff == 2'd3 && sel_ff) begin
               h_state_in = H_MOD;
            end
         end
         H_MOD: begin
            if (IS_POW2 || (ph_ff == 2'd2 && cnt_ff == 2'd3)) begin
               h_state_in = H_DONE;
            end
         end
         H_DONE: begin
            h_state_in = H_IDLE;
         end
         default: begin
            h_state_in = H_IDLE;
         end
      endcase
   end

   always_comb begin
      mul_a = 32'd0;
      mul_b = 32'd0;
      done  = (h_state_ff == H_DONE);
      if (h_state_ff == H_MUL) begin
         case (ph_ff)
            2'd0: begin
               mul_a = v_ff[31:0];
               mul_b = const_sel[31:0];
            end
            2'd1: begin
               mul_a = v_ff[31:0];
               mul_b = const_sel[63:32];
            end
            2'd2: begin
               mul_a = v_ff[63:32];
               mul_b = const_sel[31:0];
            end
            default: begin
               mul_a = 32'd0;
               mul_b = 32'd0;
            end
         endcase
      end else if (h_state_ff == H_MOD) begin
         case (ph_ff)
            2'd0: begin
               mul_a = x_mod;
               mul_b = RECIP;
            end
            2'd1: begin
               mul_a = product[63:32];
               mul_b = WIDTH_32;
            end
            default: begin
               mul_a = 32'd0;
               mul_b = 32'd0;
            end
         endcase
      end
   end

   always_comb begin
      v_in   = v_ff;
      acc_in = acc_ff;
      ph_in  = ph_ff;
      sel_in = sel_ff;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      col_in = col_ff;
      case (h_state_ff)
         H_IDLE: begin
            v_in   = x_val ^ (x_val >> FMIX_SHIFT);
            ph_in  = 2'd0;
            sel_in = 1'b0;
         end
         H_MUL: begin
            ph_in  = ph_ff + 2'd1;
            cnt_in = 2'd0;
            rem_in = '0;
            case (ph_ff)
               2'd1: begin
                  acc_in = product;
               end
               2'd2: begin
                  acc_in = t_val;
               end
               2'd3: begin
                  v_in   = t_val ^ (t_val >> FMIX_SHIFT);
                  sel_in = 1'b1;
               end
               default: begin
                  acc_in = acc_ff;
               end
            endcase
         end
         H_MOD: begin
            if (IS_POW2) begin
               col_in = v_ff[COL_BITS-1:0];
            end else begin
               case (ph_ff)
                  2'd0: begin
                     ph_in = 2'd1;
                  end
                  2'd1: begin
                     ph_in = 2'd2;
                  end
                  default: begin
                     ph_in  = 2'd0;
                     v_in   = v_ff << 16;
                     rem_in = rem_step;
                     cnt_in = cnt_ff + 2'd1;
                     if (cnt_ff == 2'd3) begin
                        col_in = rem_step;
                     end
                  end
               endcase
            end
         end
         default: begin
            v_in = v_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h_state_ff <= H_IDLE;
         ph_ff      <= 2'd0;
         sel_ff     <= 1'b0;
         cnt_ff     <= 2'd0;
      end else begin
         h_state_ff <= h_state_in;
         ph_ff      <= ph_in;
         sel_ff     <= sel_in;
         cnt_ff     <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff   <= v_in;
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      col_ff <= col_in;
   end

   assign col = col_ff;
endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for the count-min sketch with a local predictor.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import cms_pkg::*;

   localparam int ROW_WIDTH    = 1024;
   localparam int ROW_COUNT    = 4;
   localparam int COUNT_BITS   = 32;
   localparam int CELL_TOTAL   = ROW_WIDTH * ROW_COUNT;
   localparam int IDLE_LIMIT   = 20000;
   localparam int RANDOM_ITEMS = 1000;
   localparam int RANDOM_PHASES = 8;
   localparam int HOT_KEYS     = 16;
   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam logic [COUNT_BITS-1:0] CELL_MAX = '1;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_wr_en = 1'b0;
   logic [31:0] csr_wr_data = '0;

   logic [COUNT_BITS-1:0] sketch_cells [CELL_TOTAL];
   logic                  over_flag;
   logic [31:0]           threshold;
   rsp_type               pending_estimates [$];

   int error_count = 0;
   int result_count = 0;
   int idle_cycles = 0;
   int stall_run = 0;
   int burst_left = 1;
   bit steady_pace = 1'b1;
   bit valid_held = 1'b0;
   int n_add = 0;
   int n_estimate = 0;
   int n_clear = 0;
   int n_unused = 0;
   int n_flag_results = 0;
   int n_thresholds = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   count_min_sketch_top #(
      .ROW_WIDTH  (ROW_WIDTH),
      .ROW_COUNT  (ROW_COUNT),
      .COUNT_BITS (COUNT_BITS)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   function automatic logic [63:0] mix64(logic [63:0] v);
      v = v ^ (v >> FMIX_SHIFT);
      v = v * FMIX_C1;
      v = v ^ (v >> FMIX_SHIFT);
      v = v * FMIX_C2;
      v = v ^ (v >> FMIX_SHIFT);
      return v;
   endfunction

   function automatic int cell_of(logic [63:0] key, int row);
      logic [63:0] row_bits;
      logic [63:0] hashed;
      row_bits = 64'(row);
      hashed = mix64(key ^ row_bits);
      return row * ROW_WIDTH + int'(hashed % ROW_WIDTH);
   endfunction

   function automatic rsp_type apply_to_sketch(req_type item);
      rsp_type               res;
      logic [COUNT_BITS-1:0] lowest;
      int                    idx;
      res = '0;
      case (item.kind)
         KIND_ADD: begin
            n_add++;
            for (int r = 0; r < ROW_COUNT; r++) begin
               idx = cell_of(item.key, r);
               if (sketch_cells[idx] != CELL_MAX) begin
                  sketch_cells[idx] = sketch_cells[idx] + 1'b1;
               end
               if (sketch_cells[idx] > threshold) begin
                  over_flag = 1'b1;
               end
            end
         end
         KIND_ESTIMATE: begin
            n_estimate++;
            lowest = CELL_MAX;
            for (int r = 0; r < ROW_COUNT; r++) begin
               idx = cell_of(item.key, r);
               if (sketch_cells[idx] < lowest) begin
                  lowest = sketch_cells[idx];
               end
            end
            res.count_estimate = (lowest > EST_MAX) ? EST_MAX : 32'(lowest);
         end
         KIND_CLEAR: begin
            n_clear++;
            foreach (sketch_cells[i]) begin
               sketch_cells[i] = '0;
            end
            over_flag = 1'b0;
         end
         default: begin
            n_unused++;
         end
      endcase
      res.flush_needed = over_flag;
      return res;
   endfunction

   task automatic send_item(input logic [1:0] kind, input logic [63:0] key);
      req_type item;
      item.kind = kind;
      item.key = key;
      req_valid <= 1'b1;
      req_data <= item;
      valid_held = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_estimates.push_back(apply_to_sketch(item));
      if (!steady_pace) begin
         burst_left--;
         if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 16);
            req_valid <= 1'b0;
            valid_held = 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   endtask

   task automatic wait_for_results();
      if (valid_held) begin
         req_valid <= 1'b0;
         valid_held = 1'b0;
      end
      while (pending_estimates.size() != 0) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [31:0] value);
      wait_for_results();
      while (req_stall) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      threshold = value;
      n_thresholds++;
      @(posedge clock);
   endtask

   task automatic test_idle_after_reset();
      steady_pace = 1'b1;
      send_item(KIND_ESTIMATE, '0);
      send_item(KIND_ESTIMATE, '1);
      send_item(KIND_UNUSED, 64'h0123_4567_89ab_cdef);
      wait_for_results();
   endtask

   task automatic test_add_and_estimate();
      steady_pace = 1'b0;
      send_item(KIND_ADD, '0);
      send_item(KIND_ADD, '1);
      send_item(KIND_ADD, '1);
      send_item(KIND_ADD, 64'hAAAA_AAAA_AAAA_AAAA);
      send_item(KIND_ADD, 64'h5555_5555_5555_5555);
      send_item(KIND_ESTIMATE, '0);
      send_item(KIND_ESTIMATE, '1);
      send_item(KIND_ESTIMATE, 64'hAAAA_AAAA_AAAA_AAAA);
      send_item(KIND_ESTIMATE, 64'h5555_5555_5555_5555);
      send_item(KIND_UNUSED, '1);
      send_item(KIND_CLEAR, '1);
      send_item(KIND_ESTIMATE, '1);
      wait_for_results();
   endtask

   task automatic test_flush_threshold();
      steady_pace = 1'b0;
      write_threshold('0);
      send_item(KIND_ADD, 64'h1);
      send_item(KIND_UNUSED, '0);
      send_item(KIND_CLEAR, '0);
      write_threshold('1);
      repeat (3) send_item(KIND_ADD, 64'h2);
      // Lowering the threshold under existing counts must not raise the flag by itself.
      write_threshold(32'd2);
      send_item(KIND_ESTIMATE, 64'h2);
      send_item(KIND_ADD, 64'h2);
      send_item(KIND_CLEAR, '0);
      write_threshold(THRESH_RESET);
   endtask

   task automatic test_random_traffic();
      logic [63:0] hot_keys [HOT_KEYS];
      logic [63:0] key;
      logic [1:0]  kind;
      int          pick;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         steady_pace = (phase == 3);
         case (phase % 4)
            0: write_threshold($urandom_range(0, 8));
            1: write_threshold($urandom());
            2: write_threshold($urandom_range(0, 40));
            default: write_threshold((phase == 3) ? 32'hFFFF_FFFF : 32'h0);
         endcase
         foreach (hot_keys[i]) begin
            hot_keys[i] = {$urandom(), $urandom()};
         end
         for (int sent = 0; sent < RANDOM_ITEMS / RANDOM_PHASES; sent++) begin
            pick = $urandom_range(0, 999);
            if (pick < 4) begin
               kind = KIND_CLEAR;
            end else if (pick < 30) begin
               kind = KIND_UNUSED;
            end else if (pick < 550) begin
               kind = KIND_ADD;
            end else begin
               kind = KIND_ESTIMATE;
            end
            if ($urandom_range(0, 4) == 0) begin
               key = {$urandom(), $urandom()};
            end else begin
               key = hot_keys[$urandom_range(0, HOT_KEYS - 1)];
            end
            send_item(kind, key);
         end
      end
      wait_for_results();
   endtask

   always @(posedge clock) begin
      if (steady_pace) begin
         rsp_stall <= 1'b0;
      end else if (stall_run == 0) begin
         stall_run <= $urandom_range(1, 20);
         rsp_stall <= ($urandom_range(0, 99) < 35);
      end else begin
         stall_run <= stall_run - 1;
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         result_count++;
         if (pending_estimates.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result: estimate %0d flag %0b", $time,
                     rsp_data.count_estimate, rsp_data.flush_needed);
         end else begin
            want = pending_estimates.pop_front();
            if (want.flush_needed) begin
               n_flag_results++;
            end
            if (want.count_estimate !== rsp_data.count_estimate) begin
               error_count++;
               $display("%0t: count_estimate expected %0d actual %0d", $time,
                        want.count_estimate, rsp_data.count_estimate);
            end
            if (want.flush_needed !== rsp_data.flush_needed) begin
               error_count++;
               $display("%0t: flush_needed expected %0b actual %0b", $time,
                        want.flush_needed, rsp_data.flush_needed);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      foreach (sketch_cells[i]) begin
         sketch_cells[i] = '0;
      end
      over_flag = 1'b0;
      threshold = THRESH_RESET;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_idle_after_reset();
      test_add_and_estimate();
      test_flush_threshold();
      test_random_traffic();
      wait_for_results();
      repeat (100) @(posedge clock);
      $display("Covered %0d adds, %0d estimates, %0d clears and %0d unused-kind beats.",
               n_add, n_estimate, n_clear, n_unused);
      $display("Compared %0d results over %0d threshold settings; %0d carried the flag.",
               result_count, n_thresholds, n_flag_results);
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
